// ===== rtl/gfk_pkg.sv =====
`timescale 1ns / 1ps

package gfk_pkg;

    localparam int FRAC_BITS = 16;
    localparam int RES_W     = 11;
    localparam int MAX_RES   = 1024;

    localparam logic [2:0] REG_X_RES  = 3'd0;
    localparam logic [2:0] REG_Y_RES  = 3'd1;
    localparam logic [2:0] REG_KX     = 3'd2;
    localparam logic [2:0] REG_KY     = 3'd3;
    localparam logic [2:0] REG_SIGMA  = 3'd4;
    localparam logic [2:0] REG_PREF   = 3'd5;
    localparam logic [2:0] REG_DCFREE = 3'd6;
    localparam logic [2:0] REG_EPS    = 3'd7;

    localparam logic [RES_W-1:0] RESET_RES   = 11'd128;
    localparam logic [15:0]      RESET_SIGMA = 16'd1608;
    localparam logic [23:0]      RESET_PREF  = 24'd65536;
    localparam logic [31:0]      RESET_S2    = 32'd2585664;

    localparam logic [34:0] TWO_PI_Q32 = 35'h6_487E_D511;
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;

    localparam int WRAP_QW   = 10;
    localparam int OMEGA_QW  = 28;
    localparam int RATIO_QW  = 38;
    localparam int KK_W      = 38;
    localparam int SUM_W     = 59;
    localparam int A_W       = 39;
    localparam int E_W       = 33;
    localparam int N_W       = 7;
    localparam int EXP_STEPS = 14;
    localparam int EXP_ZERO_N = 40;

    localparam logic [A_W-1:0] EXP_CAP = 39'h40_0000_0000;

    localparam int RATIO_LAT = 3 + RATIO_QW;
    localparam int EXP_LAT   = N_W + 2 * EXP_STEPS + 1;

    localparam logic signed [26:0] VAL_MAX = 27'sd16777215;
    localparam logic signed [26:0] VAL_MIN = -27'sd16777216;

    // floor(t / k) == (t * EXP_RECIP[k]) >> EXP_SHIFT[k] for any 32-bit t
    localparam int EXP_SHIFT [15] = '{0, 32, 33, 34, 34, 35, 35, 35, 35,
                                      36, 36, 36, 36, 36, 36};

    localparam logic [33:0] EXP_RECIP [15] = '{
        34'd0,
        34'((64'd1 << 32) / 64'd1 + 64'd1),
        34'((64'd1 << 33) / 64'd2 + 64'd1),
        34'((64'd1 << 34) / 64'd3 + 64'd1),
        34'((64'd1 << 34) / 64'd4 + 64'd1),
        34'((64'd1 << 35) / 64'd5 + 64'd1),
        34'((64'd1 << 35) / 64'd6 + 64'd1),
        34'((64'd1 << 35) / 64'd7 + 64'd1),
        34'((64'd1 << 35) / 64'd8 + 64'd1),
        34'((64'd1 << 36) / 64'd9 + 64'd1),
        34'((64'd1 << 36) / 64'd10 + 64'd1),
        34'((64'd1 << 36) / 64'd11 + 64'd1),
        34'((64'd1 << 36) / 64'd12 + 64'd1),
        34'((64'd1 << 36) / 64'd13 + 64'd1),
        34'((64'd1 << 36) / 64'd14 + 64'd1)
    };

endpackage

// ===== rtl/gfk_div_pipe.sv =====
`timescale 1ns / 1ps

module gfk_div_pipe #(
    parameter int DEN_W = 11,
    parameter int QUO_W = 28
) (
    input  logic             clk,
    input  logic [DEN_W-1:0] rem_in,
    input  logic [QUO_W-1:0] bits_in,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] acc_reg [QUO_W];

    genvar s;
    generate
        for (s = 0; s < QUO_W; s++)
        begin : g_stage
            logic [DEN_W-1:0] r_prev;
            logic [QUO_W-1:0] a_prev;
            logic [DEN_W:0]   trial;
            logic [DEN_W:0]   diff;
            logic             ge;
            logic [DEN_W-1:0] rem_next;

            if (s == 0)
            begin : g_first
                assign r_prev = rem_in;
                assign a_prev = bits_in;
            end
            else
            begin : g_rest
                assign r_prev = rem_reg[s-1];
                assign a_prev = acc_reg[s-1];
            end

            assign trial    = {r_prev, a_prev[QUO_W-1]};
            assign diff     = trial - {1'b0, den};
            assign ge       = (trial >= {1'b0, den});
            assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

            always_ff @(posedge clk)
            begin
                rem_reg[s] <= rem_next;
                acc_reg[s] <= {a_prev[QUO_W-2:0], ge};
            end
        end
    endgenerate

    assign quo = acc_reg[QUO_W-1];
    assign rem = rem_reg[QUO_W-1];

endmodule

// ===== rtl/gfk_delay.sv =====
`timescale 1ns / 1ps

module gfk_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= d;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

// ===== rtl/gfk_ratio_pipe.sv =====
`timescale 1ns / 1ps

module gfk_ratio_pipe (
    input  logic                      clk,
    input  logic [gfk_pkg::SUM_W-1:0] sum,
    input  logic [31:0]               s2,
    input  logic [gfk_pkg::KK_W-1:0]  kk,
    output logic [gfk_pkg::A_W-1:0]   arg
);

    import gfk_pkg::*;

    logic [63:0]          pl_reg;
    logic [58:0]          ph_reg;
    logic [90:0]          prod_reg;
    logic [90:0]          prod_next;
    logic [67:0]          prod_hi;
    logic                 over_reg;
    logic [RATIO_QW-1:0]  rem_in_reg;
    logic [RATIO_QW-1:0]  bits_reg;
    logic [RATIO_QW-1:0]  quo;
    logic [KK_W-1:0]      rem_unused;
    logic                 over_late;

    assign prod_next = 91'(pl_reg) + (91'(ph_reg) << 32);
    assign prod_hi   = prod_reg[90:23];

    always_ff @(posedge clk)
    begin
        pl_reg     <= s2 * sum[31:0];
        ph_reg     <= s2 * sum[SUM_W-1:32];
        prod_reg   <= prod_next;
        over_reg   <= (prod_hi >= 68'(kk));
        rem_in_reg <= prod_reg[60:23];
        bits_reg   <= {prod_reg[22:0], 15'd0};
    end

    gfk_div_pipe #(
        .DEN_W(KK_W),
        .QUO_W(RATIO_QW)
    ) u_div (
        .clk     (clk),
        .rem_in  (rem_in_reg),
        .bits_in (bits_reg),
        .den     (kk),
        .quo     (quo),
        .rem     (rem_unused)
    );

    gfk_delay #(
        .W    (1),
        .DEPTH(RATIO_QW)
    ) u_over_dly (
        .clk (clk),
        .d   (over_reg),
        .q   (over_late)
    );

    assign arg = (over_late || (rem_unused == '1 && 1'b0)) ? EXP_CAP : {1'b0, quo};

endmodule

// ===== rtl/gfk_exp_pipe.sv =====
`timescale 1ns / 1ps

module gfk_exp_pipe (
    input  logic                    clk,
    input  logic [gfk_pkg::A_W-1:0] arg,
    output logic [gfk_pkg::E_W-1:0] value
);

    import gfk_pkg::*;

    logic [N_W-1:0]  n_int;
    logic [31:0]     r_int;
    logic [N_W-1:0]  n_late;
    logic [64:0]     prod_reg [EXP_STEPS];
    logic [65:0]     mq_reg   [EXP_STEPS];
    logic [31:0]     r_a_reg  [EXP_STEPS];
    logic [31:0]     r_b_reg  [EXP_STEPS];
    logic [65:0]     q_last;
    logic [E_W-1:0]  p_last;
    logic [E_W-1:0]  value_reg;

    gfk_div_pipe #(
        .DEN_W(32),
        .QUO_W(N_W)
    ) u_ln2_div (
        .clk     (clk),
        .rem_in  (arg[A_W-1:N_W]),
        .bits_in (arg[N_W-1:0]),
        .den     (LN2_Q32),
        .quo     (n_int),
        .rem     (r_int)
    );

    gfk_delay #(
        .W    (N_W),
        .DEPTH(2 * EXP_STEPS)
    ) u_n_dly (
        .clk (clk),
        .d   (n_int),
        .q   (n_late)
    );

    genvar j;
    generate
        for (j = 0; j < EXP_STEPS; j++)
        begin : g_step
            localparam int K = EXP_STEPS - j;
            logic [E_W-1:0] p_in;
            logic [31:0]    r_in;

            if (j == 0)
            begin : g_first
                assign p_in = ONE_Q32;
                assign r_in = r_int;
            end
            else
            begin : g_rest
                logic [65:0] q_full;
                assign q_full = mq_reg[j-1] >> EXP_SHIFT[K+1];
                assign p_in   = ONE_Q32 - {1'b0, q_full[31:0]};
                assign r_in   = r_b_reg[j-1];
            end

            always_ff @(posedge clk)
            begin
                prod_reg[j] <= p_in * r_in;
                r_a_reg[j]  <= r_in;
                mq_reg[j]   <= prod_reg[j][63:32] * EXP_RECIP[K];
                r_b_reg[j]  <= r_a_reg[j];
            end
        end
    endgenerate

    assign q_last = mq_reg[EXP_STEPS-1] >> EXP_SHIFT[1];
    assign p_last = ONE_Q32 - {1'b0, q_last[31:0]};

    always_ff @(posedge clk)
    begin
        if (n_late >= N_W'(EXP_ZERO_N))
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= p_last >> n_late;
        end
    end

    assign value = value_reg;

endmodule

// ===== rtl/gabor_frequency_kernel_pixel_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one pixel per clock; the 38-stage ratio divider and the 28-stage
//   exponent series each hold a different pixel in every stage.
// Reset clears the pipeline valid bits and loads the register defaults; done pulses
//   for one cycle per pixel and the receiver cannot stall it.

module gabor_frequency_kernel_pixel_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [9:0]  pixel_x,
    input  logic signed [9:0]  pixel_y,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output logic               done,
    output logic [9:0]         wrapped_col,
    output logic [9:0]         wrapped_row,
    output logic signed [24:0] kernel_value,
    output logic               keep
);

    import gfk_pkg::*;

    localparam int COL_IDX = 1 + WRAP_QW + 1;
    localparam int VAL_IDX = 2 + OMEGA_QW + 2 + RATIO_LAT + EXP_LAT + 2;
    localparam int COL_DLY = VAL_IDX - COL_IDX;
    localparam int VLAT    = VAL_IDX + 1;

    // configuration
    logic [RES_W-1:0]   x_res_reg, y_res_reg;
    logic signed [18:0] kx_reg, ky_reg;
    logic [15:0]        sigma_reg;
    logic [23:0]        pref_reg;
    logic               dc_free_reg;
    logic [23:0]        eps_reg;
    logic [RES_W-1:0]   rx_reg, ry_reg, rx_next, ry_next;
    logic [KK_W-1:0]    kk_reg, kk_next;
    logic [31:0]        s2_reg;
    logic signed [37:0] kxx, kyy;

    logic [VLAT-1:0]    v_reg;
    logic               accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_res_reg   <= RESET_RES;
            y_res_reg   <= RESET_RES;
            kx_reg      <= '0;
            ky_reg      <= '0;
            sigma_reg   <= RESET_SIGMA;
            pref_reg    <= RESET_PREF;
            dc_free_reg <= 1'b1;
            eps_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_X_RES:  x_res_reg   <= cfg_data[RES_W-1:0];
                REG_Y_RES:  y_res_reg   <= cfg_data[RES_W-1:0];
                REG_KX:     kx_reg      <= $signed(cfg_data[18:0]);
                REG_KY:     ky_reg      <= $signed(cfg_data[18:0]);
                REG_SIGMA:  sigma_reg   <= cfg_data[15:0];
                REG_PREF:   pref_reg    <= cfg_data;
                REG_DCFREE: dc_free_reg <= cfg_data[0];
                REG_EPS:    eps_reg     <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        rx_next = x_res_reg;
        if (x_res_reg == '0)
        begin
            rx_next = RES_W'(1);
        end
        else if (x_res_reg > RES_W'(MAX_RES))
        begin
            rx_next = RES_W'(MAX_RES);
        end
        ry_next = y_res_reg;
        if (y_res_reg == '0)
        begin
            ry_next = RES_W'(1);
        end
        else if (y_res_reg > RES_W'(MAX_RES))
        begin
            ry_next = RES_W'(MAX_RES);
        end
    end

    assign kxx     = kx_reg * kx_reg;
    assign kyy     = ky_reg * ky_reg;
    assign kk_next = $unsigned(kxx) + $unsigned(kyy);

    // derived configuration, registered from the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_reg <= RESET_RES;
            ry_reg <= RESET_RES;
            kk_reg <= '0;
            s2_reg <= RESET_S2;
        end
        else
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            kk_reg <= kk_next;
            s2_reg <= sigma_reg * sigma_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[VLAT-2:0], accept};
        end
    end

    // stage 1: capture the pixel
    logic signed [9:0] px_reg, py_reg;
    logic [9:0]        magx, magy;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
    end

    assign magx = px_reg[9] ? 10'(-px_reg) : 10'(px_reg);
    assign magy = py_reg[9] ? 10'(-py_reg) : 10'(py_reg);

    // wrap into the image
    logic [WRAP_QW-1:0] wq_x, wq_y;
    logic [RES_W-1:0]   wr_x, wr_y;
    logic               wsg_x, wsg_y;
    logic [RES_W-1:0]   col_next, row_next;
    logic [9:0]         col_reg, row_reg, col_late, row_late;

    gfk_div_pipe #(.DEN_W(RES_W), .QUO_W(WRAP_QW)) u_wrap_x (
        .clk(clk), .rem_in('0), .bits_in(magx), .den(rx_reg), .quo(wq_x), .rem(wr_x)
    );
    gfk_div_pipe #(.DEN_W(RES_W), .QUO_W(WRAP_QW)) u_wrap_y (
        .clk(clk), .rem_in('0), .bits_in(magy), .den(ry_reg), .quo(wq_y), .rem(wr_y)
    );
    gfk_delay #(.W(1), .DEPTH(WRAP_QW)) u_wsg_x (.clk(clk), .d(px_reg[9]), .q(wsg_x));
    gfk_delay #(.W(1), .DEPTH(WRAP_QW)) u_wsg_y (.clk(clk), .d(py_reg[9]), .q(wsg_y));

    assign col_next = (wsg_x && wr_x != '0) ? rx_reg - wr_x : wr_x;
    assign row_next = (wsg_y && wr_y != '0) ? ry_reg - wr_y : wr_y;

    always_ff @(posedge clk)
    begin
        col_reg <= col_next[9:0];
        row_reg <= row_next[9:0];
    end

    gfk_delay #(.W(10), .DEPTH(COL_DLY)) u_col_dly (.clk(clk), .d(col_reg), .q(col_late));
    gfk_delay #(.W(10), .DEPTH(COL_DLY)) u_row_dly (.clk(clk), .d(row_reg), .q(row_late));

    // stage 2: scale coordinate to frequency numerator
    logic [45:0] numx_full, numy_full;
    logic [29:0] numx_reg, numy_reg;
    logic        sgnx_reg, sgny_reg;

    assign numx_full = 46'(magx) * 46'(TWO_PI_Q32) + (46'(rx_reg) << (FRAC_BITS - 1));
    assign numy_full = 46'(magy) * 46'(TWO_PI_Q32) + (46'(ry_reg) << (FRAC_BITS - 1));

    always_ff @(posedge clk)
    begin
        numx_reg <= numx_full[45:FRAC_BITS];
        numy_reg <= numy_full[45:FRAC_BITS];
        sgnx_reg <= px_reg[9];
        sgny_reg <= py_reg[9];
    end

    logic [OMEGA_QW-1:0] qx, qy;
    logic [RES_W-1:0]    ox_rem, oy_rem;
    logic                osg_x, osg_y;

    gfk_div_pipe #(.DEN_W(RES_W), .QUO_W(OMEGA_QW)) u_omega_x (
        .clk(clk), .rem_in(RES_W'(numx_reg[29:OMEGA_QW])), .bits_in(numx_reg[OMEGA_QW-1:0]),
        .den(rx_reg), .quo(qx), .rem(ox_rem)
    );
    gfk_div_pipe #(.DEN_W(RES_W), .QUO_W(OMEGA_QW)) u_omega_y (
        .clk(clk), .rem_in(RES_W'(numy_reg[29:OMEGA_QW])), .bits_in(numy_reg[OMEGA_QW-1:0]),
        .den(ry_reg), .quo(qy), .rem(oy_rem)
    );
    gfk_delay #(.W(1), .DEPTH(OMEGA_QW)) u_osg_x (.clk(clk), .d(sgnx_reg), .q(osg_x));
    gfk_delay #(.W(1), .DEPTH(OMEGA_QW)) u_osg_y (.clk(clk), .d(sgny_reg), .q(osg_y));

    // squares of offset and of frequency
    logic signed [28:0] ox, oy;
    logic signed [29:0] dx, dy;
    logic [28:0]        adx, ady;
    logic [57:0]        sqdx_reg, sqdy_reg;
    logic [55:0]        sqox_reg, sqoy_reg;
    logic [SUM_W-1:0]   d2_reg, w2_reg;

    assign ox  = osg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign oy  = osg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    assign dx  = ox - kx_reg;
    assign dy  = oy - ky_reg;
    assign adx = dx[29] ? 29'(-dx) : 29'(dx);
    assign ady = dy[29] ? 29'(-dy) : 29'(dy);

    always_ff @(posedge clk)
    begin
        sqdx_reg <= adx * adx;
        sqdy_reg <= ady * ady;
        sqox_reg <= qx * qx;
        sqoy_reg <= qy * qy;
        d2_reg   <= SUM_W'(sqdx_reg) + SUM_W'(sqdy_reg);
        w2_reg   <= SUM_W'(sqox_reg) + SUM_W'(sqoy_reg) + SUM_W'(kk_reg);
    end

    logic [A_W-1:0] a1, a2;
    logic [E_W-1:0] e1, e2;

    gfk_ratio_pipe u_ratio_1 (.clk(clk), .sum(d2_reg), .s2(s2_reg), .kk(kk_reg), .arg(a1));
    gfk_ratio_pipe u_ratio_2 (.clk(clk), .sum(w2_reg), .s2(s2_reg), .kk(kk_reg), .arg(a2));
    gfk_exp_pipe   u_exp_1   (.clk(clk), .arg(a1), .value(e1));
    gfk_exp_pipe   u_exp_2   (.clk(clk), .arg(a2), .value(e2));

    // combine and saturate
    logic [56:0]        pf_reg;
    logic [17:0]        h_reg;
    logic [33:0]        h_full;
    logic [57:0]        g_full;
    logic [25:0]        g;
    logic signed [26:0] val_full;
    logic signed [24:0] val_next, val_reg;
    logic [24:0]        val_mag;
    logic signed [24:0] kval_reg;
    logic               keep_reg;
    logic [9:0]         col_out_reg, row_out_reg;

    assign h_full = 34'(e2) + (34'(1) << (31 - FRAC_BITS));
    assign g_full = 58'(pf_reg) + (58'(1) << 31);
    assign g      = g_full[57:32];

    always_comb
    begin
        val_full = $signed({1'b0, g});
        if (dc_free_reg)
        begin
            val_full = $signed({1'b0, g}) - $signed({9'b0, h_reg});
        end
        if (kk_reg == '0)
        begin
            val_next = '0;
        end
        else if (val_full > VAL_MAX)
        begin
            val_next = 25'(VAL_MAX);
        end
        else if (val_full < VAL_MIN)
        begin
            val_next = 25'(VAL_MIN);
        end
        else
        begin
            val_next = 25'(val_full);
        end
    end

    assign val_mag = val_reg[24] ? 25'(-val_reg) : 25'(val_reg);

    always_ff @(posedge clk)
    begin
        pf_reg      <= pref_reg * e1;
        h_reg       <= h_full[33:FRAC_BITS];
        val_reg     <= val_next;
        kval_reg    <= val_reg;
        keep_reg    <= (val_mag > {1'b0, eps_reg});
        col_out_reg <= col_late;
        row_out_reg <= row_late;
    end

    assign done         = v_reg[VLAT-1];
    assign kernel_value = kval_reg;
    assign keep         = keep_reg;
    assign wrapped_col  = col_out_reg;
    assign wrapped_row  = row_out_reg;

`ifndef SYNTHESIS
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##VLAT done)
        else $error("accepted word produced no result");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, VLAT))
        else $error("result without an accepted word");

    a_keep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && keep) |-> (kernel_value != '0))
        else $error("keep set on a zero value");
`endif

endmodule
